// ===== rtl/core/cdfe_pkg.sv =====
package cdfe_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int TIME_W     = 32;
    localparam int LEN_W      = 15;
    localparam int DEN_W      = 16;
    localparam int COL_W      = 8;
    localparam int DIFF_W     = DEN_W + 1;
    localparam int ACC_W      = FRAC_W + 1 + DIFF_W;
    localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);

    localparam logic [FRAC_W-1:0]       FRAC_ONE  = FRAC_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_HALF  = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [COL_W-1:0]        COL_RESET = COL_W'(77);

    localparam logic [1:0] CH_DEN = 2'd0;
    localparam logic [1:0] CH_RED = 2'd1;
    localparam logic [1:0] CH_GRN = 2'd2;
    localparam logic [1:0] CH_BLU = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_FRAC,
        S_DIV,
        S_MUL,
        S_ACC,
        S_UPDATE,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic       frac_start;
        logic       div_step;
        logic       mul;
        logic       acc;
        logic       pre;
        logic       update;
        logic       out_load;
        logic [1:0] ch;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic len_nz;
        logic div_need;
        logic div_last;
    } t_dp_sts;

endpackage

// ===== rtl/core/cdfe_dp.sv =====
module cdfe_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  cdfe_pkg::t_dp_cmd              i_cmd,
    output cdfe_pkg::t_dp_sts              o_sts,
    input  logic                           i_kind,
    input  logic [cdfe_pkg::TIME_W-1:0]    i_now_cs,
    input  logic [cdfe_pkg::DEN_W-1:0]     i_new_density,
    input  logic [cdfe_pkg::COL_W-1:0]     i_new_red,
    input  logic [cdfe_pkg::COL_W-1:0]     i_new_green,
    input  logic [cdfe_pkg::COL_W-1:0]     i_new_blue,
    input  logic [cdfe_pkg::LEN_W-1:0]     i_fade_cs,
    output logic [cdfe_pkg::DEN_W-1:0]     o_density_now,
    output logic [cdfe_pkg::COL_W-1:0]     o_red_now,
    output logic [cdfe_pkg::COL_W-1:0]     o_green_now,
    output logic [cdfe_pkg::COL_W-1:0]     o_blue_now,
    output logic                           o_fading,
    output logic                           o_fog_on
);

    logic                                r_kind;
    logic [cdfe_pkg::TIME_W-1:0]         r_now;
    logic [cdfe_pkg::DEN_W-1:0]          r_new_den;
    logic [cdfe_pkg::COL_W-1:0]          r_new_red;
    logic [cdfe_pkg::COL_W-1:0]          r_new_grn;
    logic [cdfe_pkg::COL_W-1:0]          r_new_blu;
    logic [cdfe_pkg::LEN_W-1:0]          r_new_len;

    logic [cdfe_pkg::DEN_W-1:0]          r_tgt_den;
    logic [cdfe_pkg::COL_W-1:0]          r_tgt_red;
    logic [cdfe_pkg::COL_W-1:0]          r_tgt_grn;
    logic [cdfe_pkg::COL_W-1:0]          r_tgt_blu;
    logic [cdfe_pkg::DEN_W-1:0]          r_st_den;
    logic [cdfe_pkg::COL_W-1:0]          r_st_red;
    logic [cdfe_pkg::COL_W-1:0]          r_st_grn;
    logic [cdfe_pkg::COL_W-1:0]          r_st_blu;
    logic [cdfe_pkg::LEN_W-1:0]          r_len;
    logic [cdfe_pkg::TIME_W-1:0]         r_end;

    logic [cdfe_pkg::FRAC_W-1:0]         r_frac;
    logic [cdfe_pkg::LEN_W-1:0]          r_div_rem;
    logic [cdfe_pkg::DIV_CNT_W-1:0]      r_div_cnt;
    logic signed [cdfe_pkg::ACC_W-1:0]   r_prod;
    logic                                r_fading;

    logic [cdfe_pkg::DEN_W-1:0]          r_res_den;
    logic [cdfe_pkg::COL_W-1:0]          r_res_red;
    logic [cdfe_pkg::COL_W-1:0]          r_res_grn;
    logic [cdfe_pkg::COL_W-1:0]          r_res_blu;

    logic                                fade_on;
    logic [cdfe_pkg::TIME_W-1:0]         time_left;
    logic                                frac_full;
    logic                                frac_zero;
    logic [cdfe_pkg::LEN_W:0]            div_shift;
    logic [cdfe_pkg::LEN_W:0]            div_sub;
    logic                                div_ge;
    logic [cdfe_pkg::DEN_W-1:0]          sel_s;
    logic [cdfe_pkg::DEN_W-1:0]          sel_t;
    logic signed [cdfe_pkg::DIFF_W-1:0]  st_diff;
    logic signed [cdfe_pkg::ACC_W-1:0]   prod_n;
    logic signed [cdfe_pkg::ACC_W-1:0]   acc;
    logic [cdfe_pkg::DEN_W-1:0]          blend;

    assign fade_on   = r_end > r_now;
    assign time_left = r_end - r_now;
    assign frac_full = time_left >= cdfe_pkg::TIME_W'(r_len);
    assign frac_zero = !fade_on || (r_len == '0);

    assign div_shift = {r_div_rem, 1'b0};
    assign div_ge    = div_shift >= {1'b0, r_len};
    assign div_sub   = div_shift - {1'b0, r_len};

    always_comb begin
        case (i_cmd.ch)
            cdfe_pkg::CH_DEN: begin
                sel_s = r_st_den;
                sel_t = r_tgt_den;
            end
            cdfe_pkg::CH_RED: begin
                sel_s = cdfe_pkg::DEN_W'(r_st_red);
                sel_t = cdfe_pkg::DEN_W'(r_tgt_red);
            end
            cdfe_pkg::CH_GRN: begin
                sel_s = cdfe_pkg::DEN_W'(r_st_grn);
                sel_t = cdfe_pkg::DEN_W'(r_tgt_grn);
            end
            default: begin
                sel_s = cdfe_pkg::DEN_W'(r_st_blu);
                sel_t = cdfe_pkg::DEN_W'(r_tgt_blu);
            end
        endcase
    end

    assign st_diff = $signed({1'b0, sel_s}) - $signed({1'b0, sel_t});
    assign prod_n  = cdfe_pkg::ACC_W'($signed({1'b0, r_frac})) * cdfe_pkg::ACC_W'(st_diff);
    assign acc     = $signed({{(cdfe_pkg::ACC_W - cdfe_pkg::DEN_W - cdfe_pkg::FRAC_BITS){1'b0}},
                              sel_t, {cdfe_pkg::FRAC_BITS{1'b0}}})
                     + r_prod + cdfe_pkg::ACC_HALF;
    assign blend   = acc[cdfe_pkg::FRAC_BITS +: cdfe_pkg::DEN_W];

    assign o_sts.kind     = r_kind;
    assign o_sts.len_nz   = r_new_len != '0;
    assign o_sts.div_need = !frac_zero && !frac_full;
    assign o_sts.div_last = r_div_cnt == cdfe_pkg::DIV_CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind    <= i_kind;
            r_now     <= i_now_cs;
            r_new_den <= i_new_density;
            r_new_red <= i_new_red;
            r_new_grn <= i_new_green;
            r_new_blu <= i_new_blue;
            r_new_len <= i_fade_cs;
        end
        if (i_cmd.frac_start) begin
            r_fading <= fade_on;
            if (frac_zero) begin
                r_frac <= '0;
            end else if (frac_full) begin
                r_frac <= cdfe_pkg::FRAC_ONE;
            end else begin
                r_frac    <= '0;
                r_div_rem <= time_left[cdfe_pkg::LEN_W-1:0];
                r_div_cnt <= cdfe_pkg::DIV_CNT_W'(cdfe_pkg::FRAC_BITS);
            end
        end
        if (i_cmd.div_step) begin
            r_frac    <= {r_frac[cdfe_pkg::FRAC_BITS-1:0], div_ge};
            r_div_rem <= div_ge ? div_sub[cdfe_pkg::LEN_W-1:0] : div_shift[cdfe_pkg::LEN_W-1:0];
            r_div_cnt <= r_div_cnt - cdfe_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_prod <= prod_n;
        end
        if (i_cmd.acc && !i_cmd.pre) begin
            case (i_cmd.ch)
                cdfe_pkg::CH_DEN: r_res_den <= blend;
                cdfe_pkg::CH_RED: r_res_red <= blend[cdfe_pkg::COL_W-1:0];
                cdfe_pkg::CH_GRN: r_res_grn <= blend[cdfe_pkg::COL_W-1:0];
                default:          r_res_blu <= blend[cdfe_pkg::COL_W-1:0];
            endcase
        end
        if (i_cmd.out_load) begin
            o_density_now <= r_res_den;
            o_red_now     <= r_res_red;
            o_green_now   <= r_res_grn;
            o_blue_now    <= r_res_blu;
            o_fading      <= r_fading;
            o_fog_on      <= r_res_den != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_den <= '0;
            r_tgt_red <= cdfe_pkg::COL_RESET;
            r_tgt_grn <= cdfe_pkg::COL_RESET;
            r_tgt_blu <= cdfe_pkg::COL_RESET;
            r_st_den  <= '0;
            r_st_red  <= '0;
            r_st_grn  <= '0;
            r_st_blu  <= '0;
            r_len     <= '0;
            r_end     <= '0;
        end else begin
            if (i_cmd.acc && i_cmd.pre) begin
                case (i_cmd.ch)
                    cdfe_pkg::CH_DEN: r_st_den <= blend;
                    cdfe_pkg::CH_RED: r_st_red <= blend[cdfe_pkg::COL_W-1:0];
                    cdfe_pkg::CH_GRN: r_st_grn <= blend[cdfe_pkg::COL_W-1:0];
                    default:          r_st_blu <= blend[cdfe_pkg::COL_W-1:0];
                endcase
            end
            if (i_cmd.update) begin
                r_tgt_den <= r_new_den;
                r_tgt_red <= r_new_red;
                r_tgt_grn <= r_new_grn;
                r_tgt_blu <= r_new_blu;
                r_len     <= r_new_len;
                r_end     <= r_now + cdfe_pkg::TIME_W'(r_new_len);
            end
        end
    end

endmodule

// ===== rtl/core/cdfe_ctrl.sv =====
module cdfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_load,
    output cdfe_pkg::t_dp_cmd o_cmd,
    input  cdfe_pkg::t_dp_sts i_sts
);

    cdfe_pkg::t_state r_state;
    cdfe_pkg::t_state n_state;
    logic [1:0]       r_ch;
    logic [1:0]       n_ch;
    logic             r_pre;
    logic             n_pre;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdfe_pkg::S_IDLE;
            r_ch        <= cdfe_pkg::CH_DEN;
            r_pre       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_pre       <= n_pre;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_ch             = r_ch;
        n_pre            = r_pre;
        o_cmd            = '0;
        o_cmd.ch         = r_ch;
        o_cmd.pre        = r_pre;
        o_stall          = 1'b1;
        o_load           = 1'b0;
        unique case (r_state)
            cdfe_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_load  = 1'b1;
                    n_state = cdfe_pkg::S_SETUP;
                end
            end
            cdfe_pkg::S_SETUP: begin
                n_ch = cdfe_pkg::CH_DEN;
                if (i_sts.kind && i_sts.len_nz) begin
                    n_pre   = 1'b1;
                    n_state = cdfe_pkg::S_FRAC;
                end else if (i_sts.kind) begin
                    n_pre   = 1'b0;
                    n_state = cdfe_pkg::S_UPDATE;
                end else begin
                    n_pre   = 1'b0;
                    n_state = cdfe_pkg::S_FRAC;
                end
            end
            cdfe_pkg::S_FRAC: begin
                o_cmd.frac_start = 1'b1;
                n_state = i_sts.div_need ? cdfe_pkg::S_DIV : cdfe_pkg::S_MUL;
            end
            cdfe_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = cdfe_pkg::S_MUL;
                end
            end
            cdfe_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = cdfe_pkg::S_ACC;
            end
            cdfe_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_ch == cdfe_pkg::CH_BLU) begin
                    n_ch    = cdfe_pkg::CH_DEN;
                    n_state = r_pre ? cdfe_pkg::S_UPDATE : cdfe_pkg::S_PUSH;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = cdfe_pkg::S_MUL;
                end
            end
            cdfe_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_pre        = 1'b0;
                n_state      = cdfe_pkg::S_FRAC;
            end
            cdfe_pkg::S_PUSH: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = cdfe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cdfe_pkg::S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load || (r_out_valid && i_stall);
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while a word is still in work");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdfe_pkg::S_DIV && !i_sts.div_last) |=> (r_state == cdfe_pkg::S_DIV))
        else $error("divider left before its last step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result register overwritten while its word waits");

    a_push_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdfe_pkg::S_PUSH) |-> !r_pre)
        else $error("result pushed while start values were being refreshed");
`endif

endmodule

// ===== rtl/core/color_density_fade_engine.sv =====
// Query word: fraction and blends run once, with the 16-step serial divider forming the
// fade fraction when needed; an update with zero fade length skips the pass before it.
// Update with a fade length: fraction and blends run before and after the update, and
// only the pass before it can need the divider. A new word is taken in the cycle after its
// result enters the output register, which waits while an earlier result is stalled.
// Synchronous active-low reset: colour targets 77, other fade state 0.
module color_density_fade_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [31:0] i_now_cs,
    input  logic [15:0] i_new_density,
    input  logic [7:0]  i_new_red,
    input  logic [7:0]  i_new_green,
    input  logic [7:0]  i_new_blue,
    input  logic [14:0] i_fade_cs,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_density_now,
    output logic [7:0]  o_red_now,
    output logic [7:0]  o_green_now,
    output logic [7:0]  o_blue_now,
    output logic        o_fading,
    output logic        o_fog_on
);

    cdfe_pkg::t_dp_cmd cmd;
    cdfe_pkg::t_dp_sts sts;
    logic              load;

    cdfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_load  (load),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    cdfe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_now_cs      (i_now_cs),
        .i_new_density (i_new_density),
        .i_new_red     (i_new_red),
        .i_new_green   (i_new_green),
        .i_new_blue    (i_new_blue),
        .i_fade_cs     (i_fade_cs),
        .o_density_now (o_density_now),
        .o_red_now     (o_red_now),
        .o_green_now   (o_green_now),
        .o_blue_now    (o_blue_now),
        .o_fading      (o_fading),
        .o_fog_on      (o_fog_on)
    );

endmodule

// ===== test/color_density_fade_engine_tb.sv =====
module color_density_fade_engine_tb;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;
    localparam int   HOLD_CYCLES = 400;
    localparam int   RANDOM_WORDS = 1100;

    typedef struct packed {
        logic [15:0] density;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        fading;
        logic        fog_on;
    } t_fade_view;

    class fade_scoreboard;
        logic [15:0] tgt_den;
        logic [7:0]  tgt_red;
        logic [7:0]  tgt_grn;
        logic [7:0]  tgt_blu;
        logic [15:0] st_den;
        logic [7:0]  st_red;
        logic [7:0]  st_grn;
        logic [7:0]  st_blu;
        logic [14:0] fade_len;
        logic [31:0] fade_end;
        t_fade_view  expected_views[$];
        int          errors;
        int          checked;

        function new();
            tgt_den  = '0;
            tgt_red  = cdfe_pkg::COL_RESET;
            tgt_grn  = cdfe_pkg::COL_RESET;
            tgt_blu  = cdfe_pkg::COL_RESET;
            st_den   = '0;
            st_red   = '0;
            st_grn   = '0;
            st_blu   = '0;
            fade_len = '0;
            fade_end = '0;
            errors   = 0;
            checked  = 0;
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        function logic [cdfe_pkg::FRAC_W-1:0] fraction_left(input logic [31:0] now,
                                                            output logic fading);
            logic [31:0]     gap;
            longint unsigned rem;
            fading = fade_end > now;
            if (!fading || fade_len == 0) begin
                return '0;
            end
            gap = fade_end - now;
            rem = gap;
            if (rem > fade_len) begin
                rem = fade_len;
            end
            rem = (rem << cdfe_pkg::FRAC_BITS) / fade_len;
            return cdfe_pkg::FRAC_W'(rem);
        endfunction

        function logic [15:0] blend(input logic [cdfe_pkg::FRAC_W-1:0] f,
                                    input logic [15:0] start, input logic [15:0] target);
            longint unsigned fw;
            longint unsigned sw;
            longint unsigned tw;
            longint unsigned acc;
            fw  = f;
            sw  = start;
            tw  = target;
            acc = fw * sw + ((64'd1 << cdfe_pkg::FRAC_BITS) - fw) * tw
                  + (64'd1 << (cdfe_pkg::FRAC_BITS - 1));
            return 16'(acc >> cdfe_pkg::FRAC_BITS);
        endfunction

        function void note_word(input logic kind, input logic [31:0] now,
                                input logic [15:0] den, input logic [7:0] red,
                                input logic [7:0] grn, input logic [7:0] blu,
                                input logic [14:0] len);
            logic [cdfe_pkg::FRAC_W-1:0] f;
            logic                        fading;
            t_fade_view                  v;
            if (kind == KIND_UPDATE) begin
                if (len != 0) begin
                    f      = fraction_left(now, fading);
                    st_den = blend(f, st_den, tgt_den);
                    st_red = 8'(blend(f, st_red, tgt_red));
                    st_grn = 8'(blend(f, st_grn, tgt_grn));
                    st_blu = 8'(blend(f, st_blu, tgt_blu));
                end
                tgt_den  = den;
                tgt_red  = red;
                tgt_grn  = grn;
                tgt_blu  = blu;
                fade_len = len;
                fade_end = now + 32'(len);
            end
            f         = fraction_left(now, fading);
            v.density = blend(f, st_den, tgt_den);
            v.red     = 8'(blend(f, st_red, tgt_red));
            v.green   = 8'(blend(f, st_grn, tgt_grn));
            v.blue    = 8'(blend(f, st_blu, tgt_blu));
            v.fading  = fading;
            v.fog_on  = v.density != 0;
            expected_views.push_back(v);
        endfunction

        function void check_result(input t_fade_view got);
            t_fade_view want;
            string      bad;
            checked++;
            if (expected_views.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result word at %0t: density %0d rgb %0d/%0d/%0d",
                             $time, got.density, got.red, got.green, got.blue);
                end
                return;
            end
            want = expected_views.pop_front();
            bad  = "";
            if (got.density !== want.density) bad = {bad, " density"};
            if (got.red !== want.red) bad = {bad, " red"};
            if (got.green !== want.green) bad = {bad, " green"};
            if (got.blue !== want.blue) bad = {bad, " blue"};
            if (got.fading !== want.fading) bad = {bad, " fading"};
            if (got.fog_on !== want.fog_on) bad = {bad, " fog_on"};
            if (bad != "") begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch at %0t in%s: expected %0d %0d/%0d/%0d f%0b g%0b,",
                             $time, bad, want.density, want.red, want.green, want.blue,
                             want.fading, want.fog_on,
                             " got %0d %0d/%0d/%0d f%0b g%0b",
                             got.density, got.red, got.green, got.blue,
                             got.fading, got.fog_on);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [31:0] i_now_cs = '0;
    logic [15:0] i_new_density = '0;
    logic [7:0]  i_new_red = '0;
    logic [7:0]  i_new_green = '0;
    logic [7:0]  i_new_blue = '0;
    logic [14:0] i_fade_cs = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_density_now;
    logic [7:0]  o_red_now;
    logic [7:0]  o_green_now;
    logic [7:0]  o_blue_now;
    logic        o_fading;
    logic        o_fog_on;

    fade_scoreboard sb;
    t_fade_view     seen_view;
    logic [31:0]    clock_cs;
    logic           hold_request = 1'b0;
    int             hold_left = 0;
    int             stall_run = 0;
    int             steady_left = 0;
    int             words_sent = 0;
    int             updates_sent = 0;
    int             backward_steps = 0;

    color_density_fade_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_now_cs      (i_now_cs),
        .i_new_density (i_new_density),
        .i_new_red     (i_new_red),
        .i_new_green   (i_new_green),
        .i_new_blue    (i_new_blue),
        .i_fade_cs     (i_fade_cs),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_density_now (o_density_now),
        .o_red_now     (o_red_now),
        .o_green_now   (o_green_now),
        .o_blue_now    (o_blue_now),
        .o_fading      (o_fading),
        .o_fog_on      (o_fog_on)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_view.density = o_density_now;
            seen_view.red     = o_red_now;
            seen_view.green   = o_green_now;
            seen_view.blue    = o_blue_now;
            seen_view.fading  = o_fading;
            seen_view.fog_on  = o_fog_on;
            sb.check_result(seen_view);
        end
    end

    // The receiver counts its own long hold-off once one has been requested.
    initial begin
        int r;
        forever begin
            @(negedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (stall_run > 0) begin
                stall_run--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    i_stall   = 1'b0;
                    stall_run = $urandom_range(0, 40);
                end else if (r < 80) begin
                    i_stall = 1'($urandom_range(0, 1));
                end else if (r < 96) begin
                    i_stall   = 1'b1;
                    stall_run = $urandom_range(1, 4);
                end else begin
                    i_stall   = 1'b1;
                    stall_run = $urandom_range(20, 80);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_word(input logic kind, input logic [31:0] now, input logic [15:0] den,
                             input logic [7:0] red, input logic [7:0] grn,
                             input logic [7:0] blu, input logic [14:0] len);
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_kind        = kind;
        i_now_cs      = now;
        i_new_density = den;
        i_new_red     = red;
        i_new_green   = grn;
        i_new_blue    = blu;
        i_fade_cs     = len;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sb.note_word(kind, now, den, red, grn, blu, len);
        words_sent++;
        if (kind == KIND_UPDATE) begin
            updates_sent++;
        end
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    task automatic pause_sender();
        int r;
        if (steady_left > 0) begin
            steady_left--;
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            steady_left = $urandom_range(10, 60);
        end else if (r < 55) begin
            return;
        end else if (r < 90) begin
            idle_sender($urandom_range(1, 4));
        end else begin
            idle_sender($urandom_range(15, 120));
        end
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0) begin
            idle_sender(1);
        end
    endtask

    task automatic send_random_word();
        int          r;
        logic        kind;
        logic [14:0] len;
        logic [15:0] den;
        r = $urandom_range(0, 99);
        if (r < 78) begin
            clock_cs += 32'($urandom_range(0, 300));
        end else if (r < 86) begin
            clock_cs += 32'($urandom_range(1000, 40000));
        end else if (r < 92) begin
            clock_cs = $urandom;
        end else begin
            clock_cs -= 32'($urandom_range(1, 3000));
            backward_steps++;
        end
        kind = ($urandom_range(0, 99) < 35) ? KIND_UPDATE : KIND_QUERY;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            len = '0;
        end else if (r < 57) begin
            len = 15'($urandom_range(1, 600));
        end else if (r < 92) begin
            len = 15'($urandom_range(601, 32767));
        end else begin
            len = 15'h7FFF;
        end
        r = $urandom_range(0, 99);
        if (r < 15) begin
            den = '0;
        end else if (r < 25) begin
            den = 16'hFFFF;
        end else begin
            den = 16'($urandom);
        end
        send_word(kind, clock_cs, den, 8'($urandom), 8'($urandom), 8'($urandom), len);
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(KIND_QUERY, 32'd0, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_UPDATE, 32'd100, 16'hFFFF, 8'd255, 8'd255, 8'd255, 15'h7FFF);
        send_word(KIND_QUERY, 32'd16483, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_QUERY, 32'd32866, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_UPDATE, 32'd40000, 16'd0, 8'd0, 8'd0, 8'd0, 15'd1);
        send_word(KIND_QUERY, 32'd40000, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_QUERY, 32'd40001, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_UPDATE, 32'd50000, 16'd1234, 8'd10, 8'd20, 8'd30, 15'd0);
        send_word(KIND_QUERY, 32'd49000, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_UPDATE, 32'd60000, 16'd300, 8'd200, 8'd100, 8'd50, 15'd100);
        send_word(KIND_QUERY, 32'd60050, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_UPDATE, 32'd60060, 16'd1, 8'd255, 8'd0, 8'd128, 15'd200);
        send_word(KIND_QUERY, 32'd59000, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_QUERY, 32'd60160, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_QUERY, 32'd60260, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_UPDATE, 32'hFFFF_FF00, 16'hFFFF, 8'd0, 8'd255, 8'd0, 15'd1000);
        send_word(KIND_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF);
        send_word(KIND_UPDATE, 32'hFFFF_0000, 16'h8000, 8'h55, 8'hAA, 8'h01, 15'h7FFF);
        send_word(KIND_QUERY, 32'hFFFF_4000, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_QUERY, 32'h0000_0000, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        send_word(KIND_UPDATE, 32'd200, 16'd0, 8'd0, 8'd0, 8'd0, 15'd0);
        wait_for_results();

        clock_cs = $urandom;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_random_word();
            if (n == 300) begin
                hold_request = 1'b1;
            end
            if (n == 700) begin
                wait_for_results();
            end
            pause_sender();
        end

        wait_for_results();
        idle_sender(60);
        $display("Sent %0d words (%0d updates), %0d with time stepping backwards.",
                 words_sent, updates_sent, backward_steps);
        $display("Checked %0d results, including a receiver hold-off of %0d cycles.",
                 sb.checked, HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cdfe_pkg.sv
rtl/core/cdfe_dp.sv
rtl/core/cdfe_ctrl.sv
rtl/core/color_density_fade_engine.sv
test/color_density_fade_engine_tb.sv
